// ===== hw/rtl/rfdc_pkg.sv =====
package rfdc_pkg;

   // Ring geometry: one slot always stays empty
   localparam int RING_DEPTH = 512;
   localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int DROP_W     = 32;
   localparam int BYTE_W     = 8;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [DROP_W-1:0] drop_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // Request codes; the spare code acts as a status query
   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_QUERY = 2'd2
   } mode_type;

   // Step a ring pointer, wrapping at the ring depth
   function automatic ptr_type ring_advance(input ptr_type p);
      ptr_type r;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/rfdc_ram.sv =====
module rfdc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rx_ring_fifo_with_drop_count.sv =====
// Channel   | Direction | Handshake          | Payload
// req_      | in        | req_valid/req_stall | req_mode, req_rx_byte
// rsp_      | out       | rsp_valid/rsp_stall | rsp_read_byte, rsp_read_valid,
//           |           |                     | rsp_push_stored, rsp_data_waiting,
//           |           |                     | rsp_drop_total
//
// Push, query and pop on an empty ring register their result directly; a pop that
// finds data first reads the ring memory, whose output is registered, then presents it.
// Synchronous reset clears the pointers, drop counter and result valid; the
// ring memory is not cleared, since no entry is read before it is written.
// A stalled result holds in the output register and stalls requests.
module rx_ring_fifo_with_drop_count
   import rfdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_byte,
   output logic        rsp_read_valid,
   output logic        rsp_push_stored,
   output logic        rsp_data_waiting,
   output logic [31:0] rsp_drop_total
);

   ptr_type  wr_ptr_ff, wr_ptr_in;
   ptr_type  rd_ptr_ff, rd_ptr_in;
   drop_type drop_ff, drop_in;
   logic     pend_ff, pend_in;
   logic     rsp_valid_ff, rsp_valid_in;
   byte_type byte_ff, byte_in;
   logic     rvalid_ff, rvalid_in;
   logic     stored_ff, stored_in;
   logic     waiting_ff, waiting_in;
   drop_type total_ff, total_in;

   logic     accept;
   logic     out_free;
   logic     ring_full;
   logic     ring_empty;
   ptr_type  wr_next;
   ptr_type  rd_next;
   logic     ram_we;
   logic     ram_re;
   byte_type ram_rdata;

   // Ring memory
   rfdc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_rx_byte),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // Handshake: hold requests while a read is in flight or the result waits
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = pend_ff | ~out_free;
   assign accept    = req_valid & ~req_stall;

   assign wr_next    = ring_advance(wr_ptr_ff);
   assign rd_next    = ring_advance(rd_ptr_ff);
   assign ring_full  = (wr_next == rd_ptr_ff);
   assign ring_empty = (wr_ptr_ff == rd_ptr_ff);

   // Next state: update pointers, counter and the result register
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      drop_in      = drop_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      byte_in      = byte_ff;
      rvalid_in    = rvalid_ff;
      stored_in    = stored_ff;
      waiting_in   = waiting_ff;
      total_in     = total_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      // retire a taken result
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // finish a pop with the memory data
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         byte_in      = ram_rdata;
      end

      if (accept) begin
         byte_in   = '0;
         rvalid_in = 1'b0;
         stored_in = 1'b0;
         case (req_mode)
            MODE_PUSH: begin
               if (ring_full) begin
                  drop_in = drop_ff + 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  wr_ptr_in = wr_next;
                  stored_in = 1'b1;
               end
               waiting_in   = 1'b1;
               total_in     = drop_in;
               rsp_valid_in = 1'b1;
            end
            MODE_POP: begin
               total_in = drop_ff;
               if (ring_empty) begin
                  waiting_in   = 1'b0;
                  rsp_valid_in = 1'b1;
               end else begin
                  ram_re     = 1'b1;
                  rd_ptr_in  = rd_next;
                  pend_in    = 1'b1;
                  rvalid_in  = 1'b1;
                  waiting_in = (rd_next != wr_ptr_ff);
               end
            end
            default: begin
               waiting_in   = ~ring_empty;
               total_in     = drop_ff;
               rsp_valid_in = 1'b1;
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         drop_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      rvalid_ff  <= rvalid_in;
      stored_ff  <= stored_in;
      waiting_ff <= waiting_in;
      total_ff   <= total_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_byte    = byte_ff;
   assign rsp_read_valid   = rvalid_ff;
   assign rsp_push_stored  = stored_ff;
   assign rsp_data_waiting = waiting_ff;
   assign rsp_drop_total   = total_ff;

   // A pop in flight always finds the result register empty
   a_pend_out_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("pop read in flight while result register busy");

   // A pop in flight presents its result on the next cycle
   a_pend_result: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> (rsp_valid_ff && rvalid_ff))
      else $error("pop result not presented after memory read");

   // A pop result never also reports a stored push
   a_excl_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rvalid_ff) |-> !stored_ff)
      else $error("read_valid and push_stored both set");

   // The drop counter only moves on an accepted push into a full ring
   a_drop_cause: assert property (@(posedge clock) disable iff (reset)
      (drop_in != drop_ff) |-> (accept && req_mode == MODE_PUSH && ring_full))
      else $error("drop counter changed without a dropped push");

endmodule

// ===== tb/sv/rx_ring_check_pkg.sv =====
`timescale 1ns / 100ps

package rx_ring_check_pkg;
   import rfdc_pkg::*;

   // Spare request code, behaves as a status query
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // One reply of the block, field for field
   typedef struct packed {
      byte_type read_byte;
      logic     read_valid;
      logic     push_stored;
      logic     data_waiting;
      drop_type drop_total;
   } ring_reply_type;

   class rx_ring_tracker;
      byte_type       slots [RING_DEPTH];
      int unsigned    head;
      int unsigned    tail;
      drop_type       drops;
      ring_reply_type awaited_replies [$];
      int unsigned    errors;

      function new();
         head   = 0;
         tail   = 0;
         drops  = '0;
         errors = 0;
      endfunction

      function int unsigned wrap_next(input int unsigned p);
         return (p + 1) % RING_DEPTH;
      endfunction

      function int unsigned fill_level();
         return (head + RING_DEPTH - tail) % RING_DEPTH;
      endfunction

      function int unsigned outstanding();
         return awaited_replies.size();
      endfunction

      // Advance the ring copy by one accepted item and queue its reply
      function void note_request(input logic [1:0] mode, input byte_type data);
         ring_reply_type want;
         want = '0;
         if (mode == MODE_PUSH) begin
            // keep one slot empty; a push into a full ring only counts a drop
            if (wrap_next(head) == tail) begin
               drops = drops + 1'b1;
            end else begin
               slots[head]      = data;
               head             = wrap_next(head);
               want.push_stored = 1'b1;
            end
         end else if (mode == MODE_POP) begin
            if (head != tail) begin
               want.read_byte  = slots[tail];
               want.read_valid = 1'b1;
               tail            = wrap_next(tail);
            end
         end
         want.data_waiting = (head != tail);
         want.drop_total   = drops;
         awaited_replies.push_back(want);
      endfunction

      // Compare one accepted reply with the oldest one waiting
      function void check_reply(input ring_reply_type got);
         ring_reply_type want;
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected reply, read_byte %0h read_valid %0b push_stored %0b",
                     $time, got.read_byte, got.read_valid, got.push_stored);
            errors++;
            return;
         end
         want = awaited_replies.pop_front();
         if (got.read_byte !== want.read_byte) begin
            $display("%0t: read_byte expected %0h got %0h",
                     $time, want.read_byte, got.read_byte);
            errors++;
         end
         if (got.read_valid !== want.read_valid) begin
            $display("%0t: read_valid expected %0b got %0b",
                     $time, want.read_valid, got.read_valid);
            errors++;
         end
         if (got.push_stored !== want.push_stored) begin
            $display("%0t: push_stored expected %0b got %0b",
                     $time, want.push_stored, got.push_stored);
            errors++;
         end
         if (got.data_waiting !== want.data_waiting) begin
            $display("%0t: data_waiting expected %0b got %0b",
                     $time, want.data_waiting, got.data_waiting);
            errors++;
         end
         if (got.drop_total !== want.drop_total) begin
            $display("%0t: drop_total expected %0d got %0d",
                     $time, want.drop_total, got.drop_total);
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/rx_ring_fifo_with_drop_count_tb.sv =====
`timescale 1ns / 100ps

module rx_ring_fifo_with_drop_count_tb;
   import rfdc_pkg::*;
   import rx_ring_check_pkg::*;

   localparam int PHASE_LEN     = 320;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 10;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode    = MODE_QUERY;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [7:0]  rsp_read_byte;
   logic        rsp_read_valid;
   logic        rsp_push_stored;
   logic        rsp_data_waiting;
   logic [31:0] rsp_drop_total;

   rx_ring_tracker ring_board = new();
   int             sent       = 0;
   int             hold_left  = 0;
   bit             hold_done  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rx_ring_fifo_with_drop_count dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_push_stored  (rsp_push_stored),
      .rsp_data_waiting (rsp_data_waiting),
      .rsp_drop_total   (rsp_drop_total)
   );

   // Offer one item after a random gap and hold it until accepted
   task automatic offer_item(input logic [1:0] mode, input logic [7:0] data);
      int idle_pct;
      idle_pct = (sent < PHASE_LEN) ? 35 : (sent < 2 * PHASE_LEN) ? 54 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      ring_board.note_request(mode, data);
      sent++;
   endtask

   // Pick a request code with the given push and pop weights in percent
   function automatic logic [1:0] pick_mode(input int push_pct, input int pop_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         return MODE_PUSH;
      end
      if (roll < push_pct + pop_pct) begin
         return MODE_POP;
      end
      return roll[0] ? MODE_QUERY : MODE_SPARE;
   endfunction

   // Check each accepted reply, then choose the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ring_board.check_reply(ring_reply_type'{rsp_read_byte, rsp_read_valid,
                                                 rsp_push_stored, rsp_data_waiting,
                                                 rsp_drop_total});
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (sent >= 2 * PHASE_LEN && !hold_done) begin
         // hold off for a long stretch so the block backs up into the input
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) <
                       ((sent < PHASE_LEN) ? 54 : (sent < 2 * PHASE_LEN) ? 35 : 0));
      end
   end

   // Stimulus
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty ring, byte extremes, spare code, ignored byte on pop and query
      offer_item(MODE_QUERY, 8'h00);
      offer_item(MODE_POP, 8'hFF);
      offer_item(MODE_SPARE, 8'hFF);
      offer_item(MODE_PUSH, 8'h00);
      offer_item(MODE_PUSH, 8'hFF);
      offer_item(MODE_QUERY, 8'hFF);
      offer_item(MODE_POP, 8'h00);
      offer_item(MODE_POP, 8'h00);
      offer_item(MODE_POP, 8'h00);
      offer_item(MODE_PUSH, 8'h5A);
      offer_item(MODE_SPARE, 8'h00);
      offer_item(MODE_PUSH, 8'hA5);
      offer_item(MODE_POP, 8'hFF);
      offer_item(MODE_POP, 8'hFF);
      offer_item(MODE_POP, 8'hFF);

      // Mixed traffic around a nearly empty ring
      repeat (60) offer_item(pick_mode(40, 40), 8'($urandom_range(255)));

      // Fill to capacity, drop on full, free one slot, refill and drop again
      while (ring_board.fill_level() < RING_DEPTH - 1) begin
         offer_item(pick_mode(95, 0), 8'($urandom_range(255)));
      end
      repeat (6) offer_item(MODE_PUSH, 8'($urandom_range(255)));
      offer_item(MODE_POP, 8'($urandom_range(255)));
      repeat (3) offer_item(MODE_PUSH, 8'($urandom_range(255)));

      // Drain-heavy traffic
      repeat (330) offer_item(pick_mode(15, 80), 8'($urandom_range(255)));
      req_valid <= 1'b0;

      while (ring_board.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ring_board.errors == 0 && ring_board.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
